>>> hdl/mfd_pkg.sv
// Package for the multi-format to binary32 decoder.
// Holds format codes, constants and the per-format decode functions.
package mfd_pkg;

    localparam logic [2:0] FMT_F32  = 3'd0;
    localparam logic [2:0] FMT_F16  = 3'd1;
    localparam logic [2:0] FMT_BF16 = 3'd2;
    localparam logic [2:0] FMT_I32  = 3'd3;
    localparam logic [2:0] FMT_E4M3 = 3'd4;
    localparam logic [2:0] FMT_E8M0 = 3'd5;

    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        status;
    } t_result;

    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] dec_f16(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [4:0]  p;
        logic [9:0]  mn;
        sign = {h[15], 31'd0};
        e    = h[14:10];
        m    = h[9:0];
        p    = top_bit({22'd0, m});
        mn   = m << (5'd10 - p);
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                return sign;
            end
            return sign | {1'b0, 8'(8'd103 + 8'(p)), mn, 13'd0};
        end
        if (e == 5'h1f) begin
            return sign | INF_BITS | {9'd0, m, 13'd0} | ((m != 10'd0) ? QUIET_BIT : 32'd0);
        end
        return sign | {1'b0, 8'(8'(e) + 8'd112), m, 13'd0};
    endfunction

    function automatic logic [31:0] dec_i32(input logic [31:0] w);
        logic [31:0] mag;
        logic [4:0]  p;
        logic [7:0]  ex;
        logic [31:0] norm;
        logic [24:0] q;
        logic        g;
        logic        st;
        mag  = w[31] ? (32'd0 - w) : w;
        p    = top_bit(mag);
        norm = mag << (5'd31 - p);
        ex   = 8'd127 + 8'(p);
        g    = norm[7];
        st   = |norm[6:0];
        q    = {1'b0, norm[31:8]} + 25'((g && (st || norm[8])) ? 1 : 0);
        if (q[24]) begin
            q  = q >> 1;
            ex = ex + 8'd1;
        end
        if (mag == 32'd0) begin
            return 32'd0;
        end
        return {w[31], ex, q[22:0]};
    endfunction

    function automatic logic [31:0] dec_e4m3(input logic [7:0] b);
        logic [6:0] mag;
        logic [3:0] e;
        logic [2:0] m;
        logic [4:0] p;
        logic [2:0] mn;
        mag = b[6:0];
        e   = mag[6:3];
        m   = mag[2:0];
        p   = top_bit({29'd0, m});
        mn  = m << (5'd3 - p);
        if (mag == 7'd0) begin
            return {b[7], 31'd0};
        end
        if (mag == 7'h7f) begin
            return QNAN_BITS;
        end
        if (e == 4'd0) begin
            return {b[7], 8'(8'd118 + 8'(p)), mn, 20'd0};
        end
        return {b[7], 8'(8'(e) + 8'd120), m, 20'd0};
    endfunction

    function automatic logic [31:0] dec_e8m0(input logic [7:0] b);
        if (b == 8'hff) begin
            return QNAN_BITS;
        end
        if (b == 8'd0) begin
            return QUIET_BIT;
        end
        return {1'b0, b, 23'd0};
    endfunction

endpackage

>>> hdl/mfd_if.sv
// Valid/ready channel interfaces for the decoder.
// Self-contained; no package dependencies.
interface mfd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_word;
    modport source (output valid, output raw_word, input ready);
    modport sink (input valid, input raw_word, output ready);
endinterface

interface mfd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        status;
    modport source (output valid, output value_bits, output status, input ready);
    modport sink (input valid, input value_bits, input status, output ready);
endinterface

interface mfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] source_format;
    modport source (output valid, output source_format, input ready);
    modport sink (input valid, input source_format, output ready);
endinterface

>>> hdl/multi_format_to_f32_decoder.sv
// Multi-format to binary32 decoder: input register, decode logic, result register.
// A beat passes the input register, then the result register; one beat per cycle sustained while out_ch.ready holds.
// Rate is set by the single decode stage between the two registers.
// Synchronous active-low reset clears valids and sets the format to binary32.
// Depends on mfd_pkg and the interfaces in mfd_if.
module multi_format_to_f32_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfd_cfg_if.sink       cfg,
    mfd_in_if.sink        in_ch,
    mfd_out_if.source     out_ch
);

    logic [2:0]         r_fmt;
    logic               r_in_vld;
    logic [31:0]        r_in_word;
    logic               r_out_vld;
    mfd_pkg::t_result   r_out;
    mfd_pkg::t_result   n_out;
    logic               adv;

    assign cfg.ready   = 1'b1;
    assign adv         = !r_out_vld || out_ch.ready;
    assign in_ch.ready = !r_in_vld || adv;

    always_comb begin
        n_out.status = 1'b0;
        unique case (r_fmt)
            mfd_pkg::FMT_F32:  n_out.value_bits = r_in_word;
            mfd_pkg::FMT_F16:  n_out.value_bits = mfd_pkg::dec_f16(r_in_word[15:0]);
            mfd_pkg::FMT_BF16: n_out.value_bits = {r_in_word[15:0], 16'd0};
            mfd_pkg::FMT_I32:  n_out.value_bits = mfd_pkg::dec_i32(r_in_word);
            mfd_pkg::FMT_E4M3: n_out.value_bits = mfd_pkg::dec_e4m3(r_in_word[7:0]);
            mfd_pkg::FMT_E8M0: n_out.value_bits = mfd_pkg::dec_e8m0(r_in_word[7:0]);
            default: begin
                n_out.value_bits = 32'd0;
                n_out.status     = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= mfd_pkg::FMT_F32;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg.valid) begin
                r_fmt <= cfg.source_format;
            end
            if (in_ch.ready) begin
                r_in_vld <= in_ch.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) begin
            r_in_word <= in_ch.raw_word;
        end
        if (adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign out_ch.valid      = r_out_vld;
    assign out_ch.value_bits = r_out.value_bits;
    assign out_ch.status     = r_out.status;

endmodule
